// ----- src/base40_name_codec_macros.svh -----
// Assertion helpers shared by the codec modules.
`ifndef BASE40_NAME_CODEC_MACROS_SVH
`define BASE40_NAME_CODEC_MACROS_SVH
`ifndef SYNTHESIS
`define B40NC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base40_name_codec: same-cycle check failed");
`define B40NC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base40_name_codec: next-cycle check failed");
`else
`define B40NC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define B40NC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/b40nc_pkg.sv -----
package b40nc_pkg;

    localparam int WORD_W   = 64;
    localparam int CHAR_W   = 8;
    localparam int CMD_W    = 2;
    localparam int DIGIT_W  = 6;
    localparam int CHARS_W  = 4;
    localparam int CHUNK_W  = 8;

    localparam int RADIX             = 40;
    localparam int LETTERS           = 26;
    localparam int DIGIT_UNDERSCORE  = 36;
    localparam int MAX_NAME_CHARS_DEF = 12;

    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    localparam logic [CHAR_W-1:0] CH_LC_A      = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z      = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_UC_A      = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z      = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UNDERLINE = 8'h5f;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_WORD,
        ST_EMIT_EMPTY,
        ST_DIV,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic              step;
        logic              flush;
        logic              last;
        logic [CHAR_W-1:0] char_byte;
    } enc_ctrl_t;

    typedef struct packed {
        logic              start;
        logic              load;
        logic [WORD_W-1:0] word;
    } div_ctrl_t;

    typedef struct packed {
        logic               busy;
        logic               last_step;
        logic               quot_zero;
        logic [DIGIT_W-1:0] digit;
    } div_stat_t;

    typedef struct packed {
        logic               keep;
        logic [DIGIT_W-1:0] digit;
    } digit_info_t;

    function automatic digit_info_t char_to_digit(input logic [CHAR_W-1:0] b);
        digit_info_t info;
        info.keep  = 1'b1;
        info.digit = '0;
        if (b >= CH_LC_A && b <= CH_LC_Z) begin
            info.digit = DIGIT_W'(b - CH_LC_A);
        end
        else if (b >= CH_UC_A && b <= CH_UC_Z) begin
            info.digit = DIGIT_W'(b - CH_UC_A);
        end
        else if (b >= CH_ZERO && b <= CH_NINE) begin
            info.digit = DIGIT_W'(b - CH_ZERO) + DIGIT_W'(LETTERS);
        end
        else if (b == CH_UNDERLINE) begin
            info.digit = DIGIT_W'(DIGIT_UNDERSCORE);
        end
        else begin
            info.keep = 1'b0;
        end
        return info;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        c = '0;
        if (d < DIGIT_W'(LETTERS)) begin
            c = CH_LC_A + CHAR_W'(d);
        end
        else if (d < DIGIT_W'(DIGIT_UNDERSCORE)) begin
            c = CH_ZERO + CHAR_W'(d - DIGIT_W'(LETTERS));
        end
        else if (d == DIGIT_W'(DIGIT_UNDERSCORE)) begin
            c = CH_UNDERLINE;
        end
        return c;
    endfunction

endpackage

// ----- src/b40nc_in_if.sv -----
interface b40nc_in_if;
    logic                         valid;
    logic                         ready;
    logic [b40nc_pkg::CMD_W-1:0]  command;
    logic [b40nc_pkg::CHAR_W-1:0] char_byte;
    logic                         last_char;
    logic [b40nc_pkg::WORD_W-1:0] id_word;

    modport source (output valid, command, char_byte, last_char, id_word, input ready);
    modport sink (input valid, command, char_byte, last_char, id_word, output ready);
endinterface

// ----- src/b40nc_out_if.sv -----
interface b40nc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [b40nc_pkg::WORD_W-1:0] packed_word;
    logic [b40nc_pkg::CHAR_W-1:0] char_out;
    logic                         char_valid;
    logic                         last_out;
    logic                         error;

    modport source (output valid, kind, packed_word, char_out, char_valid, last_out, error,
                    input ready);
    modport sink (input valid, kind, packed_word, char_out, char_valid, last_out, error,
                  output ready);
endinterface

// ----- src/base40_name_codec.sv -----
// Base-40 name codec.
// The items channel takes one command per beat. An encode beat adds one
// character to the name being built; when it carries the last-character
// mark, or when an end beat arrives, the packed word is registered in the
// encoder and then loaded into the output register once that is free.
// A decode beat takes a 64-bit word and returns its characters, least
// significant digit first, one result beat each, with the last one marked.
// Each digit comes out of a single divide-by-40 unit that handles eight
// bits of the word per cycle; a full word has up to thirteen digits, and
// decoding zero gives one empty beat.
// The block takes no new command while it is finishing one. While the
// receiver holds ready low with a result waiting in the output register,
// the next result is held back, but a division in progress runs on.
// Reset clears the name being built and returns the block to idle with no
// result pending.
`include "base40_name_codec_macros.svh"

module base40_name_codec #(
    parameter int MAX_NAME_CHARS = b40nc_pkg::MAX_NAME_CHARS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    b40nc_in_if.sink     items,
    b40nc_out_if.source  results
);

    b40nc_pkg::state_t    state_reg, state_next;
    b40nc_pkg::enc_ctrl_t enc_ctrl;
    b40nc_pkg::div_ctrl_t div_ctrl;
    b40nc_pkg::div_stat_t div_stat;

    logic [b40nc_pkg::WORD_W-1:0] enc_word;
    logic                         accept;
    logic                         slot_free;
    logic                         load_out;
    logic                         word_zero;

    logic                         out_valid_reg, out_valid_next;
    logic                         kind_reg, kind_next;
    logic [b40nc_pkg::WORD_W-1:0] word_reg, word_next;
    logic [b40nc_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                         cvalid_reg, cvalid_next;
    logic                         last_reg, last_next;
    logic                         error_reg, error_next;

    b40nc_enc #(
        .MAX_NAME_CHARS(MAX_NAME_CHARS)
    ) u_enc (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (enc_ctrl),
        .word (enc_word)
    );

    b40nc_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (div_ctrl),
        .stat (div_stat)
    );

    assign accept    = items.valid && items.ready;
    assign slot_free = !out_valid_reg || results.ready;
    assign word_zero = (items.id_word == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            b40nc_pkg::ST_IDLE:
            begin
                if (accept) begin
                    unique case (items.command)
                        b40nc_pkg::CMD_ENCODE:
                        begin
                            if (items.last_char) begin
                                state_next = b40nc_pkg::ST_EMIT_WORD;
                            end
                        end
                        b40nc_pkg::CMD_END:
                        begin
                            state_next = b40nc_pkg::ST_EMIT_WORD;
                        end
                        b40nc_pkg::CMD_DECODE:
                        begin
                            state_next = word_zero ? b40nc_pkg::ST_EMIT_EMPTY
                                                   : b40nc_pkg::ST_DIV;
                        end
                        default:
                        begin
                            state_next = b40nc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            b40nc_pkg::ST_EMIT_WORD, b40nc_pkg::ST_EMIT_EMPTY:
            begin
                if (slot_free) begin
                    state_next = b40nc_pkg::ST_IDLE;
                end
            end
            b40nc_pkg::ST_DIV:
            begin
                if (div_stat.last_step) begin
                    state_next = b40nc_pkg::ST_DIGIT;
                end
            end
            b40nc_pkg::ST_DIGIT:
            begin
                if (slot_free) begin
                    state_next = div_stat.quot_zero ? b40nc_pkg::ST_IDLE
                                                    : b40nc_pkg::ST_DIV;
                end
            end
            default:
            begin
                state_next = b40nc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        items.ready        = 1'b0;
        enc_ctrl.step      = 1'b0;
        enc_ctrl.flush     = 1'b0;
        enc_ctrl.last      = items.last_char;
        enc_ctrl.char_byte = items.char_byte;
        div_ctrl.start     = 1'b0;
        div_ctrl.load      = 1'b0;
        div_ctrl.word      = items.id_word;
        load_out           = 1'b0;
        kind_next          = b40nc_pkg::KIND_WORD;
        word_next          = '0;
        char_next          = '0;
        cvalid_next        = 1'b0;
        last_next          = 1'b1;
        error_next         = 1'b0;
        unique case (state_reg)
            b40nc_pkg::ST_IDLE:
            begin
                items.ready = 1'b1;
                if (accept) begin
                    unique case (items.command)
                        b40nc_pkg::CMD_ENCODE:
                        begin
                            enc_ctrl.step = 1'b1;
                        end
                        b40nc_pkg::CMD_END:
                        begin
                            enc_ctrl.flush = 1'b1;
                        end
                        b40nc_pkg::CMD_DECODE:
                        begin
                            div_ctrl.start = !word_zero;
                            div_ctrl.load  = 1'b1;
                        end
                        default:
                        begin
                            enc_ctrl.step = 1'b0;
                        end
                    endcase
                end
            end
            b40nc_pkg::ST_EMIT_WORD:
            begin
                load_out  = slot_free;
                word_next = enc_word;
            end
            b40nc_pkg::ST_EMIT_EMPTY:
            begin
                load_out  = slot_free;
                kind_next = b40nc_pkg::KIND_CHAR;
            end
            b40nc_pkg::ST_DIV:
            begin
                load_out = 1'b0;
            end
            b40nc_pkg::ST_DIGIT:
            begin
                load_out       = slot_free;
                kind_next      = b40nc_pkg::KIND_CHAR;
                char_next      = b40nc_pkg::digit_to_char(div_stat.digit);
                cvalid_next    = 1'b1;
                last_next      = div_stat.quot_zero;
                error_next     = div_stat.digit > b40nc_pkg::DIGIT_W'(b40nc_pkg::DIGIT_UNDERSCORE);
                div_ctrl.start = slot_free && !div_stat.quot_zero;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end
        else if (results.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= b40nc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out) begin
            kind_reg   <= kind_next;
            word_reg   <= word_next;
            char_reg   <= char_next;
            cvalid_reg <= cvalid_next;
            last_reg   <= last_next;
            error_reg  <= error_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.kind        = kind_reg;
    assign results.packed_word = word_reg;
    assign results.char_out    = char_reg;
    assign results.char_valid  = cvalid_reg;
    assign results.last_out    = last_reg;
    assign results.error       = error_reg;

    `B40NC_ASSERT_SAME(a_word_beat_clean, clk, rst_n, results.valid && results.kind == b40nc_pkg::KIND_WORD, !results.char_valid && !results.error && results.last_out)
    `B40NC_ASSERT_SAME(a_digit_after_div, clk, rst_n, state_reg == b40nc_pkg::ST_DIGIT, !div_stat.busy)
    `B40NC_ASSERT_NEXT(a_decode_starts, clk, rst_n, accept && items.command == b40nc_pkg::CMD_DECODE && !word_zero, state_reg == b40nc_pkg::ST_DIV && div_stat.busy)

endmodule

// ----- src/b40nc_enc.sv -----
module b40nc_enc #(
    parameter int MAX_NAME_CHARS = b40nc_pkg::MAX_NAME_CHARS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  b40nc_pkg::enc_ctrl_t         ctrl,
    output logic [b40nc_pkg::WORD_W-1:0] word
);

    logic [b40nc_pkg::WORD_W-1:0]  acc_reg, acc_next;
    logic [b40nc_pkg::WORD_W-1:0]  weight_reg, weight_next;
    logic [b40nc_pkg::CHARS_W-1:0] seen_reg, seen_next;
    logic [b40nc_pkg::WORD_W-1:0]  word_reg, word_next;
    logic [b40nc_pkg::WORD_W-1:0]  acc_sum;
    logic [b40nc_pkg::WORD_W-1:0]  weight_mul;
    logic                          room;
    b40nc_pkg::digit_info_t        info;

    assign info       = b40nc_pkg::char_to_digit(ctrl.char_byte);
    assign room       = seen_reg < b40nc_pkg::CHARS_W'(MAX_NAME_CHARS);
    assign acc_sum    = acc_reg + weight_reg * b40nc_pkg::WORD_W'(info.digit);
    assign weight_mul = (weight_reg << 5) + (weight_reg << 3);

    always_comb
    begin
        acc_next    = acc_reg;
        weight_next = weight_reg;
        seen_next   = seen_reg;
        word_next   = word_reg;
        if (ctrl.step && room) begin
            seen_next = seen_reg + 1'b1;
            if (info.keep) begin
                acc_next    = acc_sum;
                weight_next = weight_mul;
            end
        end
        if ((ctrl.step && ctrl.last) || ctrl.flush) begin
            word_next   = acc_next;
            acc_next    = '0;
            weight_next = b40nc_pkg::WORD_W'(1);
            seen_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg    <= '0;
            weight_reg <= b40nc_pkg::WORD_W'(1);
            seen_reg   <= '0;
        end
        else begin
            acc_reg    <= acc_next;
            weight_reg <= weight_next;
            seen_reg   <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ----- src/b40nc_div.sv -----
`include "base40_name_codec_macros.svh"

module b40nc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b40nc_pkg::div_ctrl_t ctrl,
    output b40nc_pkg::div_stat_t stat
);

    localparam int STEPS = b40nc_pkg::WORD_W / b40nc_pkg::CHUNK_W;
    localparam int CNT_W = $clog2(STEPS);

    logic [b40nc_pkg::WORD_W-1:0]  div_reg, div_next;
    logic [b40nc_pkg::DIGIT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic [b40nc_pkg::DIGIT_W-1:0] step_rem;
    logic [b40nc_pkg::CHUNK_W-1:0] step_quot;
    logic                          last_step;

    // Restoring division of the top chunk by the radix, one bit per inner step.
    always_comb
    begin
        logic [b40nc_pkg::DIGIT_W:0]   trial;
        logic [b40nc_pkg::DIGIT_W-1:0] r;
        r         = rem_reg;
        step_quot = '0;
        for (int i = b40nc_pkg::CHUNK_W - 1; i >= 0; i--) begin
            trial = {r, div_reg[b40nc_pkg::WORD_W - b40nc_pkg::CHUNK_W + i]};
            if (trial >= (b40nc_pkg::DIGIT_W + 1)'(b40nc_pkg::RADIX)) begin
                trial        = trial - (b40nc_pkg::DIGIT_W + 1)'(b40nc_pkg::RADIX);
                step_quot[i] = 1'b1;
            end
            r = trial[b40nc_pkg::DIGIT_W-1:0];
        end
        step_rem = r;
    end

    assign last_step = busy_reg && (cnt_reg == CNT_W'(STEPS - 1));

    always_comb
    begin
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctrl.start) begin
            if (ctrl.load) begin
                div_next = ctrl.word;
            end
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg) begin
            div_next  = {div_reg[b40nc_pkg::WORD_W-b40nc_pkg::CHUNK_W-1:0], step_quot};
            rem_next  = step_rem;
            cnt_next  = cnt_reg + 1'b1;
            busy_next = !last_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else begin
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
    end

    assign stat.busy      = busy_reg;
    assign stat.last_step = last_step;
    assign stat.quot_zero = (div_reg == '0);
    assign stat.digit     = rem_reg;

    `B40NC_ASSERT_SAME(a_rem_below_radix, clk, rst_n, 1'b1, rem_reg < b40nc_pkg::DIGIT_W'(b40nc_pkg::RADIX))
    `B40NC_ASSERT_NEXT(a_start_sets_busy, clk, rst_n, ctrl.start, busy_reg && cnt_reg == '0)
    `B40NC_ASSERT_NEXT(a_last_step_ends, clk, rst_n, last_step && !ctrl.start, !busy_reg)

endmodule

// ----- tb/base40_name_codec_checker.sv -----
module base40_name_codec_checker #(
    parameter int MAX_CHARS = b40nc_pkg::MAX_NAME_CHARS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    b40nc_in_if  items,
    b40nc_out_if results,
    output int   fail_count,
    output int   outstanding,
    output int   words_checked,
    output int   chars_checked
);
    import b40nc_pkg::*;

    localparam int MAX_DIGITS = 13;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] packed_word;
        logic [CHAR_W-1:0] char_out;
        logic              char_valid;
        logic              last_out;
        logic              error;
    } codec_beat_t;

    codec_beat_t        codec_results_due[$];
    logic [WORD_W-1:0]  name_sum;
    logic [WORD_W-1:0]  name_weight;
    logic [CHARS_W-1:0] name_len;
    int                 mismatches = 0;
    int                 words_seen = 0;
    int                 chars_seen = 0;

    task automatic predict_codec(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] b,
                                 input logic last, input logic [WORD_W-1:0] word);
        int                rank;
        int                n;
        logic [WORD_W-1:0] rest;
        logic [WORD_W-1:0] digit;
        codec_beat_t       beat;
        rank = -1;
        n = 0;
        beat = '0;
        if (cmd == CMD_ENCODE && name_len < CHARS_W'(MAX_CHARS))
        begin
            if (b >= CH_LC_A && b <= CH_LC_Z)
                rank = int'(b - CH_LC_A);
            else if (b >= CH_UC_A && b <= CH_UC_Z)
                rank = int'(b - CH_UC_A);
            else if (b >= CH_ZERO && b <= CH_NINE)
                rank = int'(b - CH_ZERO) + LETTERS;
            else if (b == CH_UNDERLINE)
                rank = DIGIT_UNDERSCORE;
            name_len = name_len + 1'b1;
            if (rank >= 0)
            begin
                name_sum = name_sum + WORD_W'(rank) * name_weight;
                name_weight = name_weight * WORD_W'(RADIX);
            end
        end
        if (cmd == CMD_END || (cmd == CMD_ENCODE && last))
        begin
            beat.kind = KIND_WORD;
            beat.packed_word = name_sum;
            beat.last_out = 1'b1;
            codec_results_due.push_back(beat);
            name_sum = '0;
            name_weight = WORD_W'(1);
            name_len = '0;
        end
        else if (cmd == CMD_DECODE)
        begin
            rest = word;
            if (rest == '0)
            begin
                beat.kind = KIND_CHAR;
                beat.last_out = 1'b1;
                codec_results_due.push_back(beat);
            end
            while (rest != '0 && n < MAX_DIGITS)
            begin
                digit = rest % WORD_W'(RADIX);
                rest = rest / WORD_W'(RADIX);
                beat = '0;
                beat.kind = KIND_CHAR;
                beat.char_valid = 1'b1;
                beat.last_out = (rest == '0);
                if (digit < LETTERS)
                    beat.char_out = CH_LC_A + CHAR_W'(digit);
                else if (digit < DIGIT_UNDERSCORE)
                    beat.char_out = CH_ZERO + CHAR_W'(digit - LETTERS);
                else if (digit == DIGIT_UNDERSCORE)
                    beat.char_out = CH_UNDERLINE;
                else
                    beat.error = 1'b1;
                codec_results_due.push_back(beat);
                n++;
            end
        end
    endtask

    task automatic compare_field(input string label, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        codec_beat_t seen;
        codec_beat_t want;
        if (!rst_n)
        begin
            codec_results_due.delete();
            name_sum = '0;
            name_weight = WORD_W'(1);
            name_len = '0;
        end
        else
        begin
            if (items.valid && items.ready)
                predict_codec(items.command, items.char_byte, items.last_char, items.id_word);
            if (results.valid && results.ready)
            begin
                seen = {results.kind, results.packed_word, results.char_out,
                        results.char_valid, results.last_out, results.error};
                if (codec_results_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with none expected, expected nothing, got %p",
                             $time, seen);
                end
                else
                begin
                    want = codec_results_due.pop_front();
                    if (want.kind == KIND_WORD)
                        words_seen++;
                    else
                        chars_seen++;
                    compare_field("kind", want.kind, seen.kind);
                    compare_field("packed_word", want.packed_word, seen.packed_word);
                    compare_field("char_out", want.char_out, seen.char_out);
                    compare_field("char_valid", want.char_valid, seen.char_valid);
                    compare_field("last_out", want.last_out, seen.last_out);
                    compare_field("error", want.error, seen.error);
                end
            end
        end
        outstanding   <= codec_results_due.size();
        fail_count    <= mismatches;
        words_checked <= words_seen;
        chars_checked <= chars_seen;
    end

endmodule

// ----- tb/base40_name_codec_test.sv -----
module base40_name_codec_test;
    import b40nc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int HALF_PERIOD  = 10;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE       = 150;
    localparam int RUN_LIMIT    = 20_000_000;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_req = 1'b0;
    int   send_idle = 0;
    int   recv_idle = 0;
    int   sent = 0;
    int   fail_count;
    int   outstanding;
    int   words_checked;
    int   chars_checked;

    b40nc_in_if  item_ch();
    b40nc_out_if result_ch();

    base40_name_codec dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch.sink),
        .results (result_ch.source)
    );

    base40_name_codec_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .items         (item_ch),
        .results       (result_ch),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .chars_checked (chars_checked)
    );

    always #(HALF_PERIOD) clk = ~clk;

    initial
    begin
        #(RUN_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // The receiver counts its long hold-off here, independent of the sender.
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
                hold_left = HOLD_CYCLES;
            if (!rst_n || hold_left != 0)
            begin
                result_ch.ready <= 1'b0;
                if (hold_left != 0)
                    hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic logic [WORD_W-1:0] any_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(9))
            0, 1, 2: return CH_LC_A + CHAR_W'($urandom_range(25));
            3, 4:    return CH_UC_A + CHAR_W'($urandom_range(25));
            5, 6:    return CH_ZERO + CHAR_W'($urandom_range(9));
            7:       return CH_UNDERLINE;
            default: return CHAR_W'($urandom);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] digits_word(input int len);
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] scale;
        w = '0;
        scale = WORD_W'(1);
        for (int i = 0; i < len; i++)
        begin
            w = w + WORD_W'($urandom_range(($urandom_range(9) == 0) ? 39 : 36)) * scale;
            scale = scale * WORD_W'(RADIX);
        end
        return w;
    endfunction

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] b,
                             input logic last, input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < send_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.command   <= cmd;
        item_ch.char_byte <= b;
        item_ch.last_char <= last;
        item_ch.id_word   <= word;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (cmd != CMD_UNUSED)
            sent++;
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_name();
        int len;
        bit close_with_end;
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 16) : $urandom_range(1, 12);
        close_with_end = ($urandom_range(7) == 0);
        for (int i = 0; i < len; i++)
            send_beat(CMD_ENCODE, pick_char(), !close_with_end && i == len - 1, any_word());
        if (close_with_end)
            send_beat(CMD_END, CHAR_W'($urandom), 1'($urandom), any_word());
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            send_name();
        else if (pick < 80)
            send_beat(CMD_DECODE, CHAR_W'($urandom), 1'($urandom),
                      digits_word($urandom_range(1, 4)));
        else if (pick < 86)
            send_beat(CMD_DECODE, CHAR_W'($urandom), 1'($urandom),
                      digits_word($urandom_range(5, 12)));
        else if (pick < 90)
            send_beat(CMD_DECODE, CHAR_W'($urandom), 1'($urandom), any_word());
        else if (pick < 93)
            send_beat(CMD_DECODE, CHAR_W'($urandom), 1'($urandom), '0);
        else if (pick < 97)
            send_beat(CMD_ENCODE, pick_char(), 1'b0, any_word());
        else
            send_beat(CMD_UNUSED, CHAR_W'($urandom), 1'($urandom), any_word());
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.command = CMD_ENCODE;
        item_ch.char_byte = '0;
        item_ch.last_char = 1'b0;
        item_ch.id_word = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 33;
        recv_idle = 58;

        // Mixed case, a digit and underscore in one name.
        send_beat(CMD_ENCODE, CH_UC_Z, 1'b0, '0);
        send_beat(CMD_ENCODE, CH_LC_Z, 1'b0, '0);
        send_beat(CMD_ENCODE, CH_NINE, 1'b0, '0);
        send_beat(CMD_ENCODE, CH_UNDERLINE, 1'b1, '1);
        // Skipped bytes still count, and the thirteenth character is dropped.
        repeat (10) send_beat(CMD_ENCODE, CH_UNDERLINE, 1'b0, '0);
        send_beat(CMD_ENCODE, 8'h00, 1'b0, '0);
        send_beat(CMD_ENCODE, 8'hff, 1'b0, '0);
        send_beat(CMD_ENCODE, CH_LC_Z, 1'b1, '0);
        send_beat(CMD_END, 8'hff, 1'b1, '1);
        send_beat(CMD_ENCODE, CH_UC_A + 8'd12, 1'b0, '0);
        send_beat(CMD_END, '0, 1'b0, '0);
        send_beat(CMD_UNUSED, 8'hff, 1'b1, '1);
        send_beat(CMD_DECODE, '0, 1'b0, '0);
        send_beat(CMD_DECODE, 8'hff, 1'b1, '1);
        send_beat(CMD_DECODE, '0, 1'b0, WORD_W'(37 + 38 * RADIX));

        while (sent < 175)
            random_item();
        wait_drained();

        send_idle = 58;
        recv_idle = 33;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        send_idle = 0;
        repeat (20)
            send_beat(CMD_DECODE, CHAR_W'($urandom), 1'($urandom),
                      digits_word($urandom_range(2, 6)));
        send_idle = 58;
        while (sent < 330)
            random_item();
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        while (sent < 460)
            random_item();
        wait_drained();

        $display("Sent %0d beats: names, end commands, decodes of zero, short and full words.",
                 sent);
        $display("Checked %0d packed words and %0d decoded characters under three idle mixes.",
                 words_checked, chars_checked);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
